>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the min/max stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define MMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked while reset is held.
`define MMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mms_pkg.sv
// Types and constants shared by the min/max stack modules.
package mms_pkg;

  localparam int DATA_W            = 32;
  localparam int STACK_DEPTH_DEF   = 64;

  // Operation carried on the input tuser bit.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stack entry: the value and the running extremes up to it.
  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  // Shift commands broadcast along the row of cells.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // Result beat as it sits in out_tdata, lowest field last.
  typedef struct packed {
    logic [4:0]               pad;
    status_t                  status;
    logic                     is_empty;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] top_value;
  } out_beat_t;

  localparam int OUT_W = $bits(out_beat_t);

  localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

endpackage

>>> hdl/min_max_stack.sv
// Top level of the min/max stack: cell row, entry counter and result register.
// The stack is a row of STACK_DEPTH cells with the top entry in cell 0; a push
// shifts every cell one place down and a pop one place up, so each cell stores
// its value together with the minimum and maximum from the bottom up to it.
// Every accepted beat yields one result beat in the next cycle holding the top,
// maximum and minimum (all -1 when empty), an empty flag and a status code.
// The block takes one beat per cycle; the only limit is the result register,
// which holds a beat until out_tready and stalls in_tready meanwhile.
// There is no clearing pass after reset; stored words need no initial value.
module min_max_stack
  import mms_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] push_value
  input  logic [0:0]        in_tuser,   // [0] func
  output logic              out_tvalid,
  input  logic              out_tready,
  // [31:0] top_value, [63:32] max_value, [95:64] min_value,
  // [96] is_empty, [98:97] status, [103:99] zero
  output logic [OUT_W-1:0]  out_tdata
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int LAST  = STACK_DEPTH - 1;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r, out_beat_nxt;

  logic                     accept;
  logic                     is_push;
  logic                     is_pop;
  logic                     full;
  logic                     empty;
  logic signed [DATA_W-1:0] push_value;
  cell_ctrl_t               ctrl;
  entry_t                   new_entry;
  entry_t                   top_nxt;
  status_t                  status;
  entry_t                   cell_q [STACK_DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Decode the beat and work out the shift command for the cell row.
  always_comb begin
    push_value = $signed(in_tdata);
    is_push    = accept && (in_tuser[0] == FUNC_PUSH);
    is_pop     = accept && (in_tuser[0] == FUNC_POP);
    full       = (count_r == CNT_W'(STACK_DEPTH));
    empty      = (count_r == '0);
    ctrl.push  = is_push && !full;
    ctrl.pop   = is_pop && !empty;
  end

  // New top entry: extremes of the pushed value and the current top.
  always_comb begin
    new_entry.value     = push_value;
    new_entry.min_value = push_value;
    new_entry.max_value = push_value;
    if (!empty) begin
      if (cell_q[0].min_value < push_value) begin
        new_entry.min_value = cell_q[0].min_value;
      end
      if (cell_q[0].max_value > push_value) begin
        new_entry.max_value = cell_q[0].max_value;
      end
    end
  end

  // Row of cells; the bottom cell keeps its word on a pop.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up_in;
    entry_t down_in;
    if (i == 0) begin : g_top
      assign up_in = new_entry;
    end else begin : g_mid
      assign up_in = cell_q[i-1];
    end
    if (i == LAST) begin : g_bot
      assign down_in = cell_q[i];
    end else begin : g_up
      assign down_in = cell_q[i+1];
    end
    mms_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .up_in   (up_in),
      .down_in (down_in),
      .q       (cell_q[i])
    );
  end

  // Entry count and the result that follows the operation.
  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (is_push && full) begin
      status = ST_FULL;
    end else if (is_pop && empty) begin
      status = ST_EMPTY;
    end

    if (ctrl.push) begin
      top_nxt = new_entry;
    end else if (ctrl.pop) begin
      top_nxt = cell_q[1];
    end else begin
      top_nxt = cell_q[0];
    end

    out_beat_nxt.pad      = '0;
    out_beat_nxt.status   = status;
    out_beat_nxt.is_empty = (count_nxt == '0);
    if (count_nxt == '0) begin
      out_beat_nxt.top_value = EMPTY_WORD;
      out_beat_nxt.max_value = EMPTY_WORD;
      out_beat_nxt.min_value = EMPTY_WORD;
    end else begin
      out_beat_nxt.top_value = top_nxt.value;
      out_beat_nxt.max_value = top_nxt.max_value;
      out_beat_nxt.min_value = top_nxt.min_value;
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r;

endmodule

>>> hdl/mms_cell.sv
// One stack cell: holds an entry and shifts it toward the top or bottom.
module mms_cell
  import mms_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     up_in,
  input  entry_t     down_in,
  output entry_t     q
);

  entry_t entry_r;

  // A push takes the entry from the cell above, a pop from the cell below.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry_r <= up_in;
    end else if (ctrl.pop) begin
      entry_r <= down_in;
    end
  end

  assign q = entry_r;

endmodule

>>> hdl/mms_checker.sv
// Port-level checks of the min/max stack, bound to the top level.
`include "assert_macros.svh"

module mms_checker
  import mms_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  out_beat_t beat;
  logic      words_empty;
  logic      top_in_range;

  assign beat = out_tdata;

  // All three value fields read as all ones.
  assign words_empty = (beat.top_value == EMPTY_WORD) && (beat.max_value == EMPTY_WORD)
                       && (beat.min_value == EMPTY_WORD);

  // Signed ordering of minimum, top and maximum.
  assign top_in_range = (beat.min_value <= beat.top_value)
                        && (beat.top_value <= beat.max_value);

  // A result beat that is not taken stays as it is.
  `MMS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // Every accepted input beat produces a result beat in the next cycle.
  `MMS_ASSERT(a_in_to_out, in_tvalid && in_tready |=> out_tvalid, "accepted beat gave no result")

  // An empty stack reports -1 in all three value fields.
  `MMS_ASSERT(a_empty_words, out_tvalid && beat.is_empty |-> words_empty, "empty stack words not all ones")

  // The top value lies between the running minimum and maximum.
  `MMS_ASSERT(a_order, out_tvalid && !beat.is_empty |-> top_in_range, "top outside min and max")

  // Reset leaves no result beat pending.
  `MMS_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind min_max_stack mms_checker u_mms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
